// ===== src/button_debounce_autorepeat_top_assert.svh =====
// ----------------------------------------------------------------------------
// button debounce assertion macros
// shared concurrent assertion forms for the debouncer modules
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_TOP_ASSERT_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_TOP_ASSERT_SVH

// same-cycle implication
`define BDA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bda assertion failed");

// next-cycle implication
`define BDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bda assertion failed");

`endif

// ===== src/bda_pkg.sv =====
// ----------------------------------------------------------------------------
// bda_pkg
// types and constants shared by the button debouncer modules
// ----------------------------------------------------------------------------
package bda_pkg;

  localparam int BDA_BUTTON_COUNT = 4;
  localparam int RAW_WIDTH        = 4;
  localparam int STATE_WIDTH      = 4;
  localparam int COUNT_WIDTH      = 8;
  localparam int IDLE_WIDTH       = 9;
  localparam int INTERVAL_WIDTH   = 10;
  localparam int ADDR_WIDTH       = 5;
  localparam int DATA_WIDTH       = 32;

  localparam logic [7:0] RESET_THRESHOLD = 8'd1;
  localparam logic [7:0] RESET_REP_START = 8'd15;
  localparam logic [7:0] RESET_REP_PERIOD = 8'd3;
  localparam logic [INTERVAL_WIDTH-1:0] RESET_FAST_MS = 10'd20;
  localparam logic [INTERVAL_WIDTH-1:0] RESET_IDLE_MS = 10'd100;

  typedef enum logic [1:0] {
    EV_CHANGE = 2'd0,
    EV_REPEAT = 2'd1,
    EV_STATUS = 2'd2
  } event_kind_t;

  typedef enum logic [2:0] {
    REG_THRESHOLD  = 3'd0,
    REG_REP_START  = 3'd1,
    REG_REP_PERIOD = 3'd2,
    REG_FAST_MS    = 3'd3,
    REG_IDLE_MS    = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0]    threshold;
    logic [7:0]                rep_start;
    logic [7:0]                rep_period;
    logic [INTERVAL_WIDTH-1:0] fast_ms;
    logic [INTERVAL_WIDTH-1:0] idle_ms;
  } cfg_t;

  typedef struct packed {
    logic stable;
    logic stable_next;
    logic change;
    logic settling;
  } lane_status_t;

endpackage

// ===== src/bda_regs.sv =====
// ----------------------------------------------------------------------------
// bda_regs
// apb register bank holding the debounce, repeat and poll interval settings
// ----------------------------------------------------------------------------
module bda_regs import bda_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  output logic [DATA_WIDTH-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_index_t index;
  logic       wr;

  assign index  = reg_index_t'(paddr[ADDR_WIDTH-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold  <= RESET_THRESHOLD;
      cfg.rep_start  <= RESET_REP_START;
      cfg.rep_period <= RESET_REP_PERIOD;
      cfg.fast_ms    <= RESET_FAST_MS;
      cfg.idle_ms    <= RESET_IDLE_MS;
    end else if (wr) begin
      case (index)
        REG_THRESHOLD:  cfg.threshold  <= pwdata[COUNT_WIDTH-1:0];
        REG_REP_START:  cfg.rep_start  <= pwdata[7:0];
        REG_REP_PERIOD: cfg.rep_period <= pwdata[7:0];
        REG_FAST_MS:    cfg.fast_ms    <= pwdata[INTERVAL_WIDTH-1:0];
        REG_IDLE_MS:    cfg.idle_ms    <= pwdata[INTERVAL_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_THRESHOLD:  prdata = DATA_WIDTH'(cfg.threshold);
      REG_REP_START:  prdata = DATA_WIDTH'(cfg.rep_start);
      REG_REP_PERIOD: prdata = DATA_WIDTH'(cfg.rep_period);
      REG_FAST_MS:    prdata = DATA_WIDTH'(cfg.fast_ms);
      REG_IDLE_MS:    prdata = DATA_WIDTH'(cfg.idle_ms);
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== src/bda_lane.sv =====
// ----------------------------------------------------------------------------
// bda_lane
// one button: stable level and saturating disagreement counter
// ----------------------------------------------------------------------------
module bda_lane import bda_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic                   level,
  input  logic [COUNT_WIDTH-1:0] threshold,
  output lane_status_t           status
);

  logic                   stable;
  logic                   stable_next;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_upd;
  logic [COUNT_WIDTH-1:0] count_next;
  logic                   change;

  always_comb begin
    if (level != stable) begin
      count_upd = (count != '1) ? count + 1'b1 : count;
    end else begin
      count_upd = (count != '0) ? count - 1'b1 : count;
    end
    change      = (count_upd >= threshold);
    count_next  = change ? '0 : count_upd;
    stable_next = change ? level : stable;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable <= 1'b1;
      count  <= '0;
    end else if (take) begin
      stable <= stable_next;
      count  <= count_next;
    end
  end

  assign status.stable      = stable;
  assign status.stable_next = stable_next;
  assign status.change      = change;
  assign status.settling    = (count_next != '0);

endmodule

// ===== src/bda_merge.sv =====
// ----------------------------------------------------------------------------
// bda_merge
// combines lane results, runs the repeat timer and sequences result beats
// ----------------------------------------------------------------------------
`include "button_debounce_autorepeat_top_assert.svh"

module bda_merge import bda_pkg::*; #(
  parameter int BUTTON_COUNT = BDA_BUTTON_COUNT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  cfg_t                             cfg,
  input  lane_status_t [BUTTON_COUNT-1:0]  lanes,
  input  logic                             tick_valid,
  output logic                             tick_ready,
  output logic                             take,
  output logic [STATE_WIDTH-1:0]           button_state,
  output logic [1:0]                       event_kind,
  output logic [INTERVAL_WIDTH-1:0]        poll_interval_ms,
  output logic                             last_of_tick,
  output logic                             result_valid,
  input  logic                             result_ready
);

  localparam int PadWidth = (BUTTON_COUNT > STATE_WIDTH) ? BUTTON_COUNT : STATE_WIDTH;

  // repeat timer
  logic [IDLE_WIDTH-1:0]  idle;
  logic [IDLE_WIDTH-1:0]  idle_next;
  logic [7:0]             phase;
  logic [7:0]             phase_next;

  // tick buffer
  logic                      buf_valid;
  logic [BUTTON_COUNT-1:0]   buf_mask;
  logic [BUTTON_COUNT-1:0]   buf_old;
  logic [BUTTON_COUNT-1:0]   buf_new;
  logic                      buf_repeat;
  logic [INTERVAL_WIDTH-1:0] buf_interval;

  // output register
  logic                      res_valid;
  logic [STATE_WIDTH-1:0]    res_state;
  event_kind_t               res_kind;
  logic [INTERVAL_WIDTH-1:0] res_interval;
  logic                      res_last;

  logic [BUTTON_COUNT-1:0]   chg_mask;
  logic [BUTTON_COUNT-1:0]   old_lvl;
  logic [BUTTON_COUNT-1:0]   new_lvl;
  logic [BUTTON_COUNT-1:0]   settle_mask;
  logic                      changed;
  logic                      busy;
  logic                      held;
  logic [IDLE_WIDTH-1:0]     idle_c;
  logic [7:0]                phase_c;
  logic [IDLE_WIDTH-1:0]     start_p1;
  logic [IDLE_WIDTH-1:0]     phase_p1;
  logic [IDLE_WIDTH-1:0]     period_eff;
  logic                      rep_now;

  logic                      step;
  logic                      last_step;
  logic [BUTTON_COUNT-1:0]   first;
  logic [BUTTON_COUNT-1:0]   upto;
  logic [BUTTON_COUNT-1:0]   chg_state;
  logic [PadWidth-1:0]       chg_pad;
  logic [PadWidth-1:0]       new_pad;

  always_comb begin
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      chg_mask[i]    = lanes[i].change;
      old_lvl[i]     = lanes[i].stable;
      new_lvl[i]     = lanes[i].stable_next;
      settle_mask[i] = lanes[i].settling;
    end
    changed    = |chg_mask;
    busy       = |settle_mask;
    held       = !(&new_lvl);
    idle_c     = changed ? '0 : idle;
    phase_c    = changed ? '0 : phase;
    start_p1   = IDLE_WIDTH'(cfg.rep_start) + 1'b1;
    phase_p1   = IDLE_WIDTH'(phase_c) + 1'b1;
    period_eff = (cfg.rep_period == '0) ? IDLE_WIDTH'(1) : IDLE_WIDTH'(cfg.rep_period);
    rep_now    = !busy && held && (idle_c > IDLE_WIDTH'(cfg.rep_start)) && (phase_c == '0);
    if (busy) begin
      idle_next  = idle_c;
      phase_next = phase_c;
    end else begin
      idle_next  = (idle_c < start_p1) ? idle_c + 1'b1 : idle_c;
      phase_next = (phase_p1 >= period_eff) ? '0 : phase_p1[7:0];
    end
  end

  // next beat out of the tick buffer
  always_comb begin
    first     = buf_mask & (~buf_mask + 1'b1);
    upto      = first | (first - 1'b1);
    chg_state = (buf_new & upto) | (buf_old & ~upto);
    chg_pad   = PadWidth'(chg_state);
    new_pad   = PadWidth'(buf_new);
    step      = buf_valid && (!res_valid || result_ready);
    last_step = step && (buf_mask == '0) && !buf_repeat;
  end

  assign tick_ready = !buf_valid || last_step;
  assign take       = tick_valid && tick_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle       <= '0;
      phase      <= '0;
      buf_valid  <= 1'b0;
      buf_repeat <= 1'b0;
      buf_mask   <= '0;
    end else if (take) begin
      idle         <= idle_next;
      phase        <= phase_next;
      buf_valid    <= 1'b1;
      buf_mask     <= chg_mask;
      buf_repeat   <= rep_now;
      buf_old      <= old_lvl;
      buf_new      <= new_lvl;
      buf_interval <= busy ? cfg.fast_ms : cfg.idle_ms;
    end else if (step) begin
      if (buf_mask != '0) begin
        buf_mask <= buf_mask & ~first;
      end else if (buf_repeat) begin
        buf_repeat <= 1'b0;
      end else begin
        buf_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (result_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (buf_mask != '0) begin
        res_state    <= chg_pad[STATE_WIDTH-1:0];
        res_kind     <= EV_CHANGE;
        res_interval <= '0;
        res_last     <= 1'b0;
      end else if (buf_repeat) begin
        res_state    <= new_pad[STATE_WIDTH-1:0];
        res_kind     <= EV_REPEAT;
        res_interval <= '0;
        res_last     <= 1'b0;
      end else begin
        res_state    <= new_pad[STATE_WIDTH-1:0];
        res_kind     <= EV_STATUS;
        res_interval <= buf_interval;
        res_last     <= 1'b1;
      end
    end
  end

  assign result_valid     = res_valid;
  assign button_state     = res_state;
  assign event_kind       = res_kind;
  assign poll_interval_ms = res_interval;
  assign last_of_tick     = res_last;

  `BDA_ASSERT_NEXT(a_take_loads, clk, rst, take, buf_valid)
  `BDA_ASSERT_NEXT(a_no_repeat_with_change, clk, rst, take, !(buf_repeat && (buf_mask != '0)))
  `BDA_ASSERT_NEXT(a_buffer_drains, clk, rst, buf_valid && !res_valid, res_valid)

endmodule

// ===== src/button_debounce_autorepeat_top.sv =====
// ----------------------------------------------------------------------------
// button_debounce_autorepeat_top
// four-button debouncer with autorepeat, one lane per button
//
//   channel   signals                                        direction
//   tick      tick_valid tick_ready raw_buttons              in
//   result    result_valid result_ready button_state         out
//             event_kind poll_interval_ms last_of_tick
//   apb       psel penable pwrite paddr pwdata prdata pready in/out
//
// a tick is taken with all lanes updating together
// a tick yields one change beat per changed button, then a repeat beat if due, then a status beat
// the next tick is taken in the cycle its predecessor's status beat leaves the tick buffer
// a stalled result beat holds the sequencer and with it tick_ready
// synchronous reset releases all buttons and clears counters and timers
// ----------------------------------------------------------------------------
module button_debounce_autorepeat_top import bda_pkg::*; #(
  parameter int BUTTON_COUNT = BDA_BUTTON_COUNT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      tick_valid,
  output logic                      tick_ready,
  input  logic [RAW_WIDTH-1:0]      raw_buttons,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic [STATE_WIDTH-1:0]    button_state,
  output logic [1:0]                event_kind,
  output logic [INTERVAL_WIDTH-1:0] poll_interval_ms,
  output logic                      last_of_tick,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_WIDTH-1:0]     paddr,
  input  logic [DATA_WIDTH-1:0]     pwdata,
  output logic [DATA_WIDTH-1:0]     prdata,
  output logic                      pready
);

  localparam int LvlWidth = (BUTTON_COUNT > RAW_WIDTH) ? BUTTON_COUNT : RAW_WIDTH;

  cfg_t                            cfg;
  lane_status_t [BUTTON_COUNT-1:0] lanes;
  logic                            take;
  logic [LvlWidth-1:0]             lvl_pad;

  assign lvl_pad = LvlWidth'(raw_buttons);

  bda_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_lane
    bda_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .take      (take),
      .level     (lvl_pad[i]),
      .threshold (cfg.threshold),
      .status    (lanes[i])
    );
  end

  bda_merge #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_merge (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .lanes            (lanes),
    .tick_valid       (tick_valid),
    .tick_ready       (tick_ready),
    .take             (take),
    .button_state     (button_state),
    .event_kind       (event_kind),
    .poll_interval_ms (poll_interval_ms),
    .last_of_tick     (last_of_tick),
    .result_valid     (result_valid),
    .result_ready     (result_ready)
  );

endmodule
